/* design/caef_pkg.sv */
package caef_pkg;

  localparam int WARMUP_SAMPLES = 16;
  localparam int ANGLE_BITS     = 14;
  localparam int TRIG_BITS      = 16;
  localparam int FRAC_BITS      = TRIG_BITS - 1;
  localparam int WORK_FRAC      = 30;
  localparam int CORDIC_STEPS   = 24;
  localparam int VEC_W          = 35;
  localparam int ANG_W          = 34;
  localparam int CNT_W          = 5;
  localparam int ACC_W          = 24;
  localparam int SCNT_W         = 5;

  localparam logic [15:0] ALPHA_RESET = 16'd13107;
  localparam logic signed [VEC_W-1:0] GAIN_INV_Q30 = 35'sd652032874;
  localparam logic [ANGLE_BITS-1:0] ANGLE_MASK = '1;

  localparam logic [0:0] REG_CLOCKWISE = 1'b0;
  localparam logic [0:0] REG_ALPHA     = 1'b1;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  function automatic logic [30:0] arc_of(input logic [CNT_W-1:0] i);
    logic [30:0] a;
    case (i)
      5'd0:  a = 31'd536870912;
      5'd1:  a = 31'd316933406;
      5'd2:  a = 31'd167458907;
      5'd3:  a = 31'd85004756;
      5'd4:  a = 31'd42667331;
      5'd5:  a = 31'd21354465;
      5'd6:  a = 31'd10679838;
      5'd7:  a = 31'd5340245;
      5'd8:  a = 31'd2670163;
      5'd9:  a = 31'd1335087;
      5'd10: a = 31'd667544;
      5'd11: a = 31'd333772;
      5'd12: a = 31'd166886;
      5'd13: a = 31'd83443;
      5'd14: a = 31'd41722;
      5'd15: a = 31'd20861;
      5'd16: a = 31'd10430;
      5'd17: a = 31'd5215;
      5'd18: a = 31'd2608;
      5'd19: a = 31'd1304;
      5'd20: a = 31'd652;
      5'd21: a = 31'd326;
      5'd22: a = 31'd163;
      5'd23: a = 31'd81;
      default: a = 31'd0;
    endcase
    return a;
  endfunction

endpackage

/* design/circular_angle_ema_filter.sv */
// Flow: each word takes 24 rotation steps for sine/cosine, then an
// accumulate during warm-up; once the average runs, the two multiplies of
// the moving average follow, then 24 vectoring steps for the angle (skipped
// when both means are zero), all on one shared CORDIC shifter/adder.
// Flow control: in_ready is high only while idle, so a new word is taken
// only once the last result is in the output register.
// Reset: synchronous, clears control, sums, count, held average, clockwise.
module circular_angle_ema_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [caef_pkg::ANGLE_BITS-1:0] raw_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [caef_pkg::ANGLE_BITS-1:0] current_angle,
  output logic [caef_pkg::ANGLE_BITS-1:0] average_angle,
  output logic        average_valid
);
  import caef_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_POST, S_ACC, S_MUL_S, S_ADD_S, S_MUL_C, S_ADD_C,
    S_VEC_GO, S_VEC, S_FIN, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic        clockwise;
  logic [15:0] alpha;
  logic        cfg_wr;

  // working state
  logic [ANGLE_BITS-1:0]      cur;
  logic                       flip;
  logic signed [TRIG_BITS-1:0] sn, cs;
  logic signed [ACC_W-1:0]    sine_acc, cos_acc;
  logic [SCNT_W-1:0]          sample_count;
  logic [ANGLE_BITS-1:0]      held_average;
  logic                       run_valid;
  logic                       base_half;
  logic signed [34:0]         prod;

  // shared CORDIC
  cordic_ctl_t             cctl;
  logic signed [VEC_W-1:0] cx0, cy0, cx, cy;
  logic signed [ANG_W-1:0] cz0, cz;
  logic                    cdone;

  caef_cordic u_cordic (
    .clk (clk), .rst (rst), .ctl (cctl),
    .x0 (cx0), .y0 (cy0), .z0 (cz0),
    .done (cdone), .x (cx), .y (cy), .z (cz)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ALPHA) ? {16'd0, alpha} : {31'd0, clockwise};
  assign in_ready = (state == S_IDLE);

  // combinational helpers
  logic [ANGLE_BITS-1:0]      cur_in;
  logic [31:0]                th;
  logic                       flip_in;
  logic signed [VEC_W-1:0]    vx, vy, rx, ry;
  logic signed [TRIG_BITS-1:0] sn_q, cs_q;
  logic signed [ACC_W-1:0]    sum_s, sum_c, mean_s, mean_c;
  logic signed [17:0]         diff;
  logic signed [ACC_W-1:0]    ema_m;
  logic signed [34:0]         prod_r;
  logic [31:0]                t_ang;
  logic [32:0]                t_rnd;

  function automatic logic signed [TRIG_BITS-1:0] to_trig(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] r;
    logic signed [VEC_W-1:0] lim;
    lim = VEC_W'((1 << FRAC_BITS) - 1);
    r = (v + VEC_W'(1 << (WORK_FRAC - FRAC_BITS - 1))) >>> (WORK_FRAC - FRAC_BITS);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[TRIG_BITS-1:0];
  endfunction

  // round to nearest, ties away from zero, divide by the warm-up count
  function automatic logic signed [ACC_W-1:0] mean_of(input logic signed [ACC_W-1:0] s);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] q;
    mag = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
    q = ACC_W'((mag + ACC_W'(WARMUP_SAMPLES / 2)) / WARMUP_SAMPLES);
    return s[ACC_W-1] ? -signed'(q) : signed'(q);
  endfunction

  always_comb begin
    cur_in  = clockwise ? (ANGLE_MASK - raw_angle) : raw_angle;
    th      = {cur_in, {(32 - ANGLE_BITS){1'b0}}};
    flip_in = (th[31:30] == 2'b01) || (th[31:30] == 2'b10);
    if (flip_in) th = th + 32'h8000_0000;
    vx   = flip ? -cx : cx;
    vy   = flip ? -cy : cy;
    cs_q = to_trig(vx);
    sn_q = to_trig(vy);
    sum_s  = sine_acc + ACC_W'(sn);
    sum_c  = cos_acc + ACC_W'(cs);
    mean_s = mean_of(sum_s);
    mean_c = mean_of(sum_c);
    // shared multiplier: sine in S_MUL_S and S_ADD_S, cosine otherwise
    if (state == S_MUL_S || state == S_ADD_S) begin
      diff  = 18'(sn) - 18'(sine_acc);
      ema_m = sine_acc;
    end else begin
      diff  = 18'(cs) - 18'(cos_acc);
      ema_m = cos_acc;
    end
    prod_r = 35'(diff) * 35'(signed'({1'b0, alpha}));
    rx = VEC_W'(cos_acc) <<< (WORK_FRAC - FRAC_BITS);
    ry = VEC_W'(sine_acc) <<< (WORK_FRAC - FRAC_BITS);
    t_ang = (base_half ? 32'h8000_0000 : 32'd0) + cz[31:0];
    t_rnd = {1'b0, t_ang} + 33'(1 << (31 - ANGLE_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      clockwise    <= 1'b0;
      alpha        <= ALPHA_RESET;
      sine_acc     <= '0;
      cos_acc      <= '0;
      sample_count <= '0;
      held_average <= '0;
      out_valid    <= 1'b0;
      cctl         <= '0;
    end else begin
      cctl.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;

      // a clockwise write restarts the warm-up and restores alpha
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_CLOCKWISE: begin
            clockwise    <= pwdata[0];
            alpha        <= ALPHA_RESET;
            sine_acc     <= '0;
            cos_acc      <= '0;
            sample_count <= '0;
            held_average <= '0;
          end
          REG_ALPHA: alpha <= pwdata[15:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur  <= cur_in;
            flip <= flip_in;
            cx0  <= GAIN_INV_Q30;
            cy0  <= '0;
            cz0  <= ANG_W'(signed'(th));
            cctl <= '{start: 1'b1, vectoring: 1'b0};
            state <= S_ROT;
          end
        end
        S_ROT: if (cdone) state <= S_POST;
        S_POST: begin
          sn <= sn_q;
          cs <= cs_q;
          state <= (sample_count < SCNT_W'(WARMUP_SAMPLES)) ? S_ACC : S_MUL_S;
        end
        S_ACC: begin
          // sum; on the last warm-up word replace sums by means
          if (sample_count == SCNT_W'(WARMUP_SAMPLES - 1)) begin
            sine_acc <= mean_s;
            cos_acc  <= mean_c;
          end else begin
            sine_acc <= sum_s;
            cos_acc  <= sum_c;
          end
          sample_count <= sample_count + 1'b1;
          run_valid <= 1'b0;
          state <= S_OUT;
        end
        S_MUL_S: begin
          prod  <= prod_r;
          state <= S_ADD_S;
        end
        S_ADD_S: begin
          sine_acc <= ACC_W'(35'(ema_m) + ((prod + 35'sd32768) >>> 16));
          state <= S_MUL_C;
        end
        S_MUL_C: begin
          prod  <= prod_r;
          state <= S_ADD_C;
        end
        S_ADD_C: begin
          cos_acc <= ACC_W'(35'(ema_m) + ((prod + 35'sd32768) >>> 16));
          state <= S_VEC_GO;
        end
        S_VEC_GO: begin
          run_valid <= 1'b1;
          if (sine_acc == '0 && cos_acc == '0) begin
            held_average <= '0;
            state <= S_OUT;
          end else begin
            // fold the left half plane over by a half turn
            base_half <= cos_acc[ACC_W-1];
            cx0  <= cos_acc[ACC_W-1] ? -rx : rx;
            cy0  <= cos_acc[ACC_W-1] ? -ry : ry;
            cz0  <= '0;
            cctl <= '{start: 1'b1, vectoring: 1'b1};
            state <= S_VEC;
          end
        end
        S_VEC: if (cdone) state <= S_FIN;
        S_FIN: begin
          held_average <= t_rnd[31:32-ANGLE_BITS];
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            current_angle <= cur;
            average_angle <= held_average;
            average_valid <= run_valid;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a word while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= SCNT_W'(WARMUP_SAMPLES))
    else $error("sample count overran warm-up");

  a_valid_after_warmup: assert property (@(posedge clk) disable iff (rst)
    (out_valid && average_valid && !$past(cfg_wr)) |->
      (sample_count == SCNT_W'(WARMUP_SAMPLES)) || $past(cfg_wr, 2))
    else $error("average reported before warm-up finished");

endmodule

/* design/caef_cordic.sv */
module caef_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  caef_pkg::cordic_ctl_t                ctl,
  input  logic signed [caef_pkg::VEC_W-1:0]    x0,
  input  logic signed [caef_pkg::VEC_W-1:0]    y0,
  input  logic signed [caef_pkg::ANG_W-1:0]    z0,
  output logic                                 done,
  output logic signed [caef_pkg::VEC_W-1:0]    x,
  output logic signed [caef_pkg::VEC_W-1:0]    y,
  output logic signed [caef_pkg::ANG_W-1:0]    z
);
  import caef_pkg::*;

  logic             busy;
  logic             vec_mode;
  logic [CNT_W-1:0] cnt;
  logic signed [VEC_W-1:0] sx, sy;
  logic signed [ANG_W-1:0] arc;
  logic             up;

  // one micro-rotation per cycle through the shared shifter and adders
  always_comb begin
    sx  = x >>> cnt;
    sy  = y >>> cnt;
    arc = ANG_W'(signed'({1'b0, arc_of(cnt)}));
    up  = vec_mode ? y[VEC_W-1] : !z[ANG_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      vec_mode <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        x <= x0;
        y <= y0;
        z <= z0;
        vec_mode <= ctl.vectoring;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (up) begin
          x <= x - sy;
          y <= y + sx;
          z <= z - arc;
        end else begin
          x <= x + sy;
          y <= y - sx;
          z <= z + arc;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* tb/circular_angle_ema_filter_tb.sv */
`timescale 1ns / 1ps

module circular_angle_ema_filter_tb;
  import caef_pkg::*;

  typedef struct {
    logic [ANGLE_BITS-1:0] cur;
    logic [ANGLE_BITS-1:0] avg;
    logic                  avg_ok;
  } angle_word_t;

  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ANGLE_BITS-1:0] raw_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ANGLE_BITS-1:0] current_angle, average_angle;
  logic average_valid;

  circular_angle_ema_filter u_top (.*);

  always #5 clk = ~clk;

  // Shadow state of the filter.
  logic        mirror_q;
  logic [15:0] alpha_q;
  longint      sin_mean, cos_mean;
  int          warm_cnt;
  logic [ANGLE_BITS-1:0] last_avg;

  logic [ANGLE_BITS-1:0] raw_pending[$];
  angle_word_t           angle_expected[$];
  int send_idle_pct = 0, recv_stall_pct = 0, hold_off = 0;
  int mismatches = 0;

  longint arcs[CORDIC_STEPS] = '{536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  // Round half up from Q2.30 to Q1.15 and clip symmetrically.
  function automatic longint q30_to_trig(longint v);
    longint lim, r;
    lim = (64'sd1 <<< FRAC_BITS) - 1;
    r = (v + (64'sd1 <<< (WORK_FRAC - FRAC_BITS - 1))) >>> (WORK_FRAC - FRAC_BITS);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  task automatic rotate_angle(input logic [ANGLE_BITS-1:0] ang,
                              output longint sn, output longint cs);
    logic [31:0] th;
    logic flip;
    longint x, y, z, dx, dy;
    th = {ang, {(32-ANGLE_BITS){1'b0}}};
    flip = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
    if (flip) th = th + 32'h8000_0000;
    z = longint'(signed'(th));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arcs[i];
      end else begin
        x += dx; y -= dy; z += arcs[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cs = q30_to_trig(x);
    sn = q30_to_trig(y);
  endtask

  function automatic logic [ANGLE_BITS-1:0] vector_angle(longint cs, longint sn);
    logic [31:0] base, t;
    longint x, y, z, dx, dy;
    logic [32:0] rounded;
    if (cs == 0 && sn == 0) return '0;
    base = 0;
    x = cs;
    y = sn;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; base = 32'h8000_0000;
    end
    x = x <<< (WORK_FRAC - FRAC_BITS);
    y = y <<< (WORK_FRAC - FRAC_BITS);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arcs[i];
      end else begin
        x -= dx; y += dy; z -= arcs[i];
      end
    end
    t = base + z[31:0];
    rounded = {1'b0, t} + (33'd1 << (31 - ANGLE_BITS));
    return rounded[31:32-ANGLE_BITS];
  endfunction

  function automatic longint warmup_mean(longint sum);
    longint mag, q;
    mag = (sum < 0) ? -sum : sum;
    q = (mag + WARMUP_SAMPLES / 2) / WARMUP_SAMPLES;
    return (sum < 0) ? -q : q;
  endfunction

  function automatic longint ema_step(longint m, longint s);
    return m + (((s - m) * longint'(alpha_q) + 32768) >>> 16);
  endfunction

  // Advance the shadow filter by one sample and queue the expected word.
  task automatic predict_filter(input logic [ANGLE_BITS-1:0] raw);
    angle_word_t w;
    longint sn, cs;
    w.cur = mirror_q ? (ANGLE_MASK - raw) : raw;
    w.avg_ok = 1'b0;
    rotate_angle(w.cur, sn, cs);
    if (warm_cnt < WARMUP_SAMPLES) begin
      sin_mean += sn;
      cos_mean += cs;
      if (warm_cnt == WARMUP_SAMPLES - 1) begin
        sin_mean = warmup_mean(sin_mean);
        cos_mean = warmup_mean(cos_mean);
      end
      warm_cnt++;
    end else begin
      sin_mean = ema_step(sin_mean, sn);
      cos_mean = ema_step(cos_mean, cs);
      last_avg = vector_angle(cos_mean, sin_mean);
      w.avg_ok = 1'b1;
    end
    w.avg = last_avg;
    angle_expected.push_back(w);
  endtask

  // Driver: predict and drop the word accepted at this edge, then offer the
  // head of the pending queue and hold it until accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_filter(raw_angle);
        void'(raw_pending.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (raw_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          raw_angle <= raw_pending[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted word against the oldest expectation.
  always @(posedge clk) begin
    angle_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (angle_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: cur=%0d avg=%0d ok=%0d",
                   current_angle, average_angle, average_valid);
      end else begin
        w = angle_expected.pop_front();
        if (w.cur !== current_angle || w.avg !== average_angle ||
            w.avg_ok !== average_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cur=%0d avg=%0d ok=%0d got cur=%0d avg=%0d ok=%0d",
                     w.cur, w.avg, w.avg_ok, current_angle, average_angle,
                     average_valid);
        end
      end
    end
  end

  // Receiver backpressure, with an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic reg_write(input int idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_CLOCKWISE) begin
      mirror_q = val[0];
      alpha_q = ALPHA_RESET;
      sin_mean = 0; cos_mean = 0; warm_cnt = 0; last_avg = '0;
    end else if (idx == REG_ALPHA) begin
      alpha_q = val[15:0];
    end
  endtask

  // Let the queues empty, then allow the block to settle.
  task automatic wait_idle();
    while (raw_pending.size() > 0 || angle_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random samples around a fixed center so the mean stays meaningful; some noise.
  task automatic queue_random(input int n);
    logic [ANGLE_BITS-1:0] center;
    center = ANGLE_BITS'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7)
        raw_pending.push_back(ANGLE_BITS'(center + ANGLE_BITS'($urandom_range(400)) - 200));
      else
        raw_pending.push_back(ANGLE_BITS'($urandom));
    end
  endtask

  initial begin
    mirror_q = 0; alpha_q = ALPHA_RESET;
    sin_mean = 0; cos_mean = 0; warm_cnt = 0; last_avg = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, cardinal points and the warm-up edge.
    raw_pending.push_back(14'd0);
    raw_pending.push_back(14'd16383);
    raw_pending.push_back(14'd4096);
    raw_pending.push_back(14'd8192);
    raw_pending.push_back(14'd12288);
    raw_pending.push_back(14'h2AAA);
    raw_pending.push_back(14'h1555);
    for (int i = 0; i < 9; i++) raw_pending.push_back(i[0] ? 14'd8192 : 14'd0);
    for (int i = 0; i < 6; i++) raw_pending.push_back(14'd8192);
    wait_idle();

    reg_write(REG_CLOCKWISE, 32'hFFFF_FFFF);
    reg_write(REG_ALPHA, 32'h0001_FFFF);
    queue_random(150);
    wait_idle();
    reg_write(REG_ALPHA, 32'd1);
    queue_random(150);
    wait_idle();
    reg_write(REG_ALPHA, 32'd0);
    queue_random(40);
    wait_idle();
    reg_write(REG_CLOCKWISE, 32'd0);

    // Idling phases: sender idle, receiver stall, both.
    send_idle_pct = 67; queue_random(200); wait_idle();
    send_idle_pct = 0; recv_stall_pct = 67; queue_random(200); wait_idle();
    reg_write(REG_ALPHA, 32'd40000);
    send_idle_pct = 25; recv_stall_pct = 25; queue_random(200); wait_idle();

    // Hold the receiver off while samples keep coming.
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 600;
    queue_random(100);
    wait_idle();
    reg_write(REG_CLOCKWISE, 32'd1);
    queue_random(220);
    wait_idle();

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
design/caef_pkg.sv
design/caef_cordic.sv
design/circular_angle_ema_filter.sv
tb/circular_angle_ema_filter_tb.sv
